// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; the including scope provides clk and
// arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg
// Types, constants and character helpers of the token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

	// Position counter width (8..32).
	localparam int POS_WIDTH = 16;
	localparam int LEN_W     = POS_WIDTH + 1;
	localparam int CHAR_W    = 8;
	localparam int KIND_W    = 6;
	localparam int TOK_W     = 16;
	localparam int SAT_W     = (LEN_W > TOK_W) ? LEN_W : TOK_W;
	localparam logic [TOK_W-1:0] TOK_MAX = {TOK_W{1'b1}};

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Token kinds
	localparam logic [KIND_W-1:0] KIND_NUMBER = KIND_W'(13);
	localparam logic [KIND_W-1:0] KIND_STRING = KIND_W'(14);
	localparam logic [KIND_W-1:0] KIND_IDENT  = KIND_W'(15);
	localparam logic [KIND_W-1:0] KIND_KW0    = KIND_W'(16);
	localparam logic [KIND_W-1:0] KIND_TERM   = KIND_W'(31);
	localparam logic [KIND_W-1:0] KIND_ERROR  = KIND_W'(32);

	// Characters
	localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
	localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h22;
	localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;

	localparam int NPUNCT = 13;
	localparam logic [CHAR_W-1:0] PUNCT_CHARS [NPUNCT] = '{
		":", ";", ",", "+", "-", "*", "/", "%", "(", ")", "[", "]", "="
	};

	// Keywords, padded to nine characters; first char in the top byte.
	localparam int NKW    = 15;
	localparam int KW_MAX = 9;
	localparam logic [8*KW_MAX-1:0] KW_TEXT [NKW] = '{
		"begin    ", "end      ", "and      ", "or       ", "create   ",
		"print    ", "if       ", "endif    ", "ifbody   ", "else     ",
		"do       ", "not      ", "while    ", "whilebody", "endwhile "
	};
	localparam logic [3:0] KW_LEN [NKW] = '{
		4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd5, 4'd2, 4'd5,
		4'd6, 4'd4, 4'd2, 4'd3, 4'd5, 4'd9, 4'd8
	};
	localparam logic [NKW-1:0] KW_ALL = {NKW{1'b1}};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TOK_W-1:0]  start;
		logic [TOK_W-1:0]  length;
	} token_t;

	// Tokens caused by one byte; tok0 always holds the first.
	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} run_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] code;
	} punct_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
	endfunction

	function automatic punct_t punct_lookup(input logic [CHAR_W-1:0] c);
		punct_t r;
		r = '0;
		for (int i = 0; i < NPUNCT; i++) begin
			if (PUNCT_CHARS[i] == c) begin
				r.hit  = 1'b1;
				r.code = 4'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] kw_char(input int k, input logic [3:0] idx);
		logic [CHAR_W-1:0] r;
		r = '0;
		for (int j = 0; j < KW_MAX; j++) begin
			if (idx == 4'(j))
				r = KW_TEXT[k][8*(KW_MAX-1-j) +: 8];
		end
		return r;
	endfunction

	// Keep only keywords whose char at idx matches c.
	function automatic logic [NKW-1:0] narrow(input logic [NKW-1:0] mask,
			input logic [3:0] idx, input logic [CHAR_W-1:0] c);
		logic [NKW-1:0] keep;
		keep = '0;
		for (int k = 0; k < NKW; k++)
			keep[k] = mask[k] && (idx < KW_LEN[k]) && (kw_char(k, idx) == c);
		return keep;
	endfunction

	// Lowest-numbered surviving keyword of matching length, else identifier.
	function automatic logic [KIND_W-1:0] ident_kind(input logic [NKW-1:0] mask,
			input logic [3:0] seen);
		logic [KIND_W-1:0] kind;
		kind = KIND_IDENT;
		for (int k = NKW - 1; k >= 0; k--) begin
			if (mask[k] && (KW_LEN[k] == seen))
				kind = KIND_KW0 + KIND_W'(k);
		end
		return kind;
	endfunction

	function automatic logic [TOK_W-1:0] sat_field(input logic [LEN_W-1:0] v);
		logic [SAT_W-1:0] w;
		w = SAT_W'(v);
		return (w > SAT_W'(TOK_MAX)) ? TOK_MAX : w[TOK_W-1:0];
	endfunction

	function automatic token_t make_tok(input logic [KIND_W-1:0] kind,
			input logic [POS_WIDTH-1:0] start, input logic [LEN_W-1:0] len);
		token_t t;
		t.kind   = kind;
		t.start  = sat_field(LEN_W'(start));
		t.length = sat_field(len);
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tsc_if.sv =====
// ----------------------------------------------------------------------------
// tsc_if
// Valid/ready channels of the token scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_byte_if;
	logic                        valid;
	logic                        ready;
	logic [tsc_pkg::CHAR_W-1:0]  char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface tsc_token_if;
	logic                        valid;
	logic                        ready;
	logic [tsc_pkg::KIND_W-1:0]  token_kind;
	logic [tsc_pkg::TOK_W-1:0]   token_start;
	logic [tsc_pkg::TOK_W-1:0]   token_len;
	logic                        last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_len, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input token_start,
		input token_len, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/tsc_front.sv =====
// ----------------------------------------------------------------------------
// tsc_front
// Scan state machine: takes one byte a cycle while the queue has space,
// classifies it and pushes the tokens it closes as one run into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tsc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	tsc_byte_if.sink            chars,
	input  wire logic           space,
	output logic                push,
	output tsc_pkg::run_t       push_run
);

	typedef enum logic [6:0] {
		M_IDLE  = 7'b0000001,
		M_INT   = 7'b0000010,
		M_DOT   = 7'b0000100,
		M_FRAC  = 7'b0001000,
		M_STR   = 7'b0010000,
		M_IDENT = 7'b0100000,
		M_HALT  = 7'b1000000
	} mode_t;

	mode_t                           mode_q, mode_d;
	logic [tsc_pkg::POS_WIDTH-1:0]   pos_q, pos_d;
	logic [tsc_pkg::POS_WIDTH-1:0]   begin_q, begin_d;
	logic [tsc_pkg::NKW-1:0]         cand_q, cand_d;
	logic [3:0]                      seen_q, seen_d;

	logic [tsc_pkg::CHAR_W-1:0]      c;
	logic                            accept;
	logic                            digit, ident_ch;
	tsc_pkg::punct_t                 pc;
	logic [tsc_pkg::LEN_W-1:0]       span;

	// between-token scan of the current byte
	logic                            i_v, i_open, i_ident, use_idle;
	mode_t                           i_mode;
	tsc_pkg::token_t                 i_tok;

	logic                            t0_v, t1_v;
	tsc_pkg::token_t                 t0, t1;

	assign c        = chars.char_code;
	assign accept   = chars.valid && chars.ready;
	assign chars.ready = space;

	always_comb begin
		digit    = tsc_pkg::is_digit(c);
		ident_ch = tsc_pkg::is_alpha(c) || digit || (c == tsc_pkg::CH_UNDERSCORE);
		pc       = tsc_pkg::punct_lookup(c);
		span     = tsc_pkg::LEN_W'(pos_q) - tsc_pkg::LEN_W'(begin_q);

		i_v     = 1'b0;
		i_tok   = '0;
		i_mode  = M_IDLE;
		i_open  = 1'b0;
		i_ident = 1'b0;
		if (c == tsc_pkg::CH_NUL) begin
			i_v   = 1'b1;
			i_tok = tsc_pkg::make_tok(tsc_pkg::KIND_TERM, pos_q, '0);
		end else if (tsc_pkg::is_blank(c)) begin
			i_v = 1'b0;
		end else if (pc.hit) begin
			i_v   = 1'b1;
			i_tok = tsc_pkg::make_tok(tsc_pkg::KIND_W'(pc.code), pos_q,
				tsc_pkg::LEN_W'(1));
		end else if (digit) begin
			i_mode = M_INT;
			i_open = 1'b1;
		end else if (c == tsc_pkg::CH_QUOTE) begin
			i_mode = M_STR;
			i_open = 1'b1;
		end else if (tsc_pkg::is_alpha(c) || (c == tsc_pkg::CH_UNDERSCORE)) begin
			i_mode  = M_IDENT;
			i_open  = 1'b1;
			i_ident = 1'b1;
		end else begin
			i_mode = M_HALT;
			i_v    = 1'b1;
			i_tok  = tsc_pkg::make_tok(tsc_pkg::KIND_ERROR, pos_q, tsc_pkg::LEN_W'(1));
		end

		mode_d   = mode_q;
		begin_d  = begin_q;
		cand_d   = cand_q;
		seen_d   = seen_q;
		t0_v     = 1'b0;
		t0       = '0;
		use_idle = 1'b0;

		case (mode_q)
			M_INT: begin
				if (c == tsc_pkg::CH_DOT) begin
					mode_d = M_DOT;
				end else if (!digit) begin
					t0_v     = 1'b1;
					t0       = tsc_pkg::make_tok(tsc_pkg::KIND_NUMBER, begin_q, span);
					use_idle = 1'b1;
				end
			end
			M_DOT: begin
				if (digit) begin
					mode_d = M_FRAC;
				end else begin
					// dot with no digit after it
					mode_d = M_HALT;
					t0_v   = 1'b1;
					t0     = tsc_pkg::make_tok(tsc_pkg::KIND_ERROR,
						(pos_q != '0) ? pos_q - 1'b1 : '0, tsc_pkg::LEN_W'(1));
				end
			end
			M_FRAC: begin
				if (!digit) begin
					t0_v     = 1'b1;
					t0       = tsc_pkg::make_tok(tsc_pkg::KIND_NUMBER, begin_q, span);
					use_idle = 1'b1;
				end
			end
			M_STR: begin
				if (c == tsc_pkg::CH_QUOTE) begin
					mode_d = M_IDLE;
					t0_v   = 1'b1;
					t0     = tsc_pkg::make_tok(tsc_pkg::KIND_STRING, begin_q,
						span + tsc_pkg::LEN_W'(1));
				end else if (c == tsc_pkg::CH_NUL) begin
					// unterminated string
					mode_d = M_HALT;
					t0_v   = 1'b1;
					t0     = tsc_pkg::make_tok(tsc_pkg::KIND_ERROR, pos_q,
						tsc_pkg::LEN_W'(1));
				end
			end
			M_IDENT: begin
				if (ident_ch) begin
					cand_d = tsc_pkg::narrow(cand_q, seen_q, c);
					seen_d = (seen_q != 4'hF) ? seen_q + 4'd1 : seen_q;
				end else begin
					t0_v     = 1'b1;
					t0       = tsc_pkg::make_tok(tsc_pkg::ident_kind(cand_q, seen_q),
						begin_q, span);
					use_idle = 1'b1;
				end
			end
			M_HALT: begin
				mode_d = M_HALT;
			end
			M_IDLE: begin
				use_idle = 1'b1;
			end
			default: begin
				use_idle = 1'b1;
			end
		endcase

		t1_v = 1'b0;
		t1   = i_tok;
		if (use_idle) begin
			mode_d = i_mode;
			t1_v   = i_v;
			if (i_open)
				begin_d = pos_q;
			if (i_ident) begin
				cand_d = tsc_pkg::narrow(tsc_pkg::KW_ALL, 4'd0, c);
				seen_d = 4'd1;
			end
		end

		pos_d = pos_q;
		if ((mode_d != M_HALT) && (pos_q != '1))
			pos_d = pos_q + 1'b1;

		push          = accept && (t0_v || t1_v);
		push_run.two  = t0_v && t1_v;
		push_run.tok0 = t0_v ? t0 : t1;
		push_run.tok1 = t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			cand_q  <= tsc_pkg::KW_ALL;
			seen_q  <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			cand_q  <= cand_d;
			seen_q  <= seen_d;
		end
	end

	`ASSERT_IMPLIES(a_halt_silent, mode_q == M_HALT, !push, "token pushed while halted")
	`ASSERT_NEXT(a_halt_frozen, mode_q == M_HALT, $stable(pos_q) && (mode_q == M_HALT),
		"position or mode moved while halted")

endmodule

`default_nettype wire

// ===== rtl/tsc_fifo.sv =====
// ----------------------------------------------------------------------------
// tsc_fifo
// Short run queue between scanner and token output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tsc_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tsc_pkg::run_t  push_run,
	output logic                space,
	input  wire logic           pop,
	output tsc_pkg::run_t       head,
	output logic                avail
);

	tsc_pkg::run_t                  mem_q [tsc_pkg::QUEUE_DEPTH];
	logic [tsc_pkg::QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [tsc_pkg::QUEUE_CW-1:0]   count_q;
	logic                           do_pop;

	localparam logic [tsc_pkg::QUEUE_AW-1:0] LAST_SLOT =
		tsc_pkg::QUEUE_AW'(tsc_pkg::QUEUE_DEPTH - 1);

	assign space  = count_q != tsc_pkg::QUEUE_CW'(tsc_pkg::QUEUE_DEPTH);
	assign avail  = count_q != '0;
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && avail;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`ASSERT_IMPLIES(a_no_overflow, push, space, "run pushed into full queue")

endmodule

`default_nettype wire

// ===== rtl/tsc_back.sv =====
// ----------------------------------------------------------------------------
// tsc_back
// Unpacks queued runs onto the token channel, one token per word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tsc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           avail,
	input  wire tsc_pkg::run_t  head,
	output logic                pop,
	tsc_token_if.source         tokens
);

	logic            sel_q;
	logic            take;
	tsc_pkg::token_t cur;

	assign cur  = sel_q ? head.tok1 : head.tok0;
	assign take = tokens.valid && tokens.ready;
	assign pop  = take && (!head.two || sel_q);

	assign tokens.valid       = avail;
	assign tokens.token_kind  = cur.kind;
	assign tokens.token_start = cur.start;
	assign tokens.token_len   = cur.length;
	assign tokens.last_of_run = sel_q || !head.two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= 1'b0;
		else if (take)
			sel_q <= head.two && !sel_q;
	end

	`ASSERT_IMPLIES(a_sel_two, sel_q, avail && head.two,
		"second token selected without a two-token run")

endmodule

`default_nettype wire

// ===== rtl/token_scanner.sv =====
// ----------------------------------------------------------------------------
// token_scanner
// Streaming lexer: source bytes in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                        width
//  chars     in   char_code                                      8
//  tokens    out  token_kind, token_start, token_len,            6/16/16/1
//                 last_of_run
//
//  Cycles: one byte word accepted per clock while the run queue has a free
//          slot; each byte closes zero, one or two tokens, pushed as one run.
//  Tokens leave one word per clock from the queue head while tokens.ready
//          is high; a byte that closes two tokens takes two output words.
//  Output: a closed token is written into the run queue as its byte is taken.
//  Stalls: chars.ready depends only on queue occupancy (four runs deep), never
//          combinationally on tokens.ready.
//  Reset: arst_n clears scan state and queue pointers; no clearing pass.
//
`default_nettype none

module token_scanner (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tsc_byte_if.sink    chars,
	tsc_token_if.source tokens
);

	// front -> queue
	logic          push;
	tsc_pkg::run_t push_run;
	logic          space;

	// queue -> back
	tsc_pkg::run_t head;
	logic          avail;
	logic          pop;

	// Scanner state machine: modes, position counter, keyword candidate mask.
	tsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.space    (space),
		.push     (push),
		.push_run (push_run)
	);

	// Decouples scanning from output back-pressure.
	tsc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.space    (space),
		.pop      (pop),
		.head     (head),
		.avail    (avail)
	);

	// Serialises each run; flags the last token of a run.
	tsc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.head   (head),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule

`default_nettype wire

// ===== tb/tb_token_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_token_scanner
// Self-checking bench for the token scanner. Source bytes go in one word per
// handshake. Tokens coming out are checked in order, field by field, against
// typed opening rows or a bench scanner model. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_token_scanner;

	// Punctuation kinds used in the opening table
	localparam logic [tsc_pkg::KIND_W-1:0] KIND_COLON  = tsc_pkg::KIND_W'(0);
	localparam logic [tsc_pkg::KIND_W-1:0] KIND_EQUALS = tsc_pkg::KIND_W'(12);

	localparam logic [tsc_pkg::POS_WIDTH-1:0] POS_LAST = '1;
	localparam int RANDOM_WORDS = 330;
	// Queue is four runs deep; this covers the tail
	localparam int DRAIN_CYCLES = 16;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_STR, SCAN_IDENT, SCAN_HALT
	} scan_state_t;

	// How the run is brought to its halt
	typedef enum logic [1:0] {
		END_BAD_BYTE, END_LONE_DOT, END_OPEN_STRING
	} run_end_t;

	typedef struct packed {
		logic [tsc_pkg::KIND_W-1:0] kind;
		logic [tsc_pkg::TOK_W-1:0]  start;
		logic [tsc_pkg::TOK_W-1:0]  length;
		logic                       last;
	} scan_token_t;

	// One row of the opening sequence. Where typed is set the expectation is
	// written here; otherwise it comes from the model below.
	typedef struct packed {
		logic [tsc_pkg::CHAR_W-1:0] code;
		logic                       typed;
		logic                       has_tok;
		logic [tsc_pkg::KIND_W-1:0] kind;
		logic [tsc_pkg::TOK_W-1:0]  start;
		logic [tsc_pkg::TOK_W-1:0]  length;
	} opening_row_t;

	localparam int N_OPENING = 24;

	// Position counts from 0 after reset. Covers terminate, the three blanks,
	// both ends of the punctuation list, a number with fraction closed by a
	// punctuation mark (two tokens from one byte), a string holding byte 255
	// and a newline, and the longest keyword.
	localparam opening_row_t OPENING_ROWS [N_OPENING] = '{
		'{tsc_pkg::CH_NUL,     1'b1, 1'b1, tsc_pkg::KIND_TERM, 16'd0, 16'd0},
		'{tsc_pkg::CH_SPACE,   1'b1, 1'b0, '0,                 '0,    '0},
		'{tsc_pkg::CH_TAB,     1'b1, 1'b0, '0,                 '0,    '0},
		'{tsc_pkg::CH_NEWLINE, 1'b1, 1'b0, '0,                 '0,    '0},
		'{":",                 1'b1, 1'b1, KIND_COLON,         16'd4, 16'd1},
		'{"=",                 1'b1, 1'b1, KIND_EQUALS,        16'd5, 16'd1},
		'{"9",                 1'b1, 1'b0, '0,                 '0,    '0},
		'{tsc_pkg::CH_DOT,     1'b1, 1'b0, '0,                 '0,    '0},
		'{"0",                 1'b1, 1'b0, '0,                 '0,    '0},
		'{"(",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{tsc_pkg::CH_QUOTE,   1'b0, 1'b0, '0,                 '0,    '0},
		'{8'hFF,               1'b0, 1'b0, '0,                 '0,    '0},
		'{tsc_pkg::CH_NEWLINE, 1'b0, 1'b0, '0,                 '0,    '0},
		'{tsc_pkg::CH_QUOTE,   1'b0, 1'b0, '0,                 '0,    '0},
		'{"w",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{"h",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{"i",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{"l",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{"e",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{"b",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{"o",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{"d",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{"y",                 1'b0, 1'b0, '0,                 '0,    '0},
		'{tsc_pkg::CH_SPACE,   1'b0, 1'b0, '0,                 '0,    '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	tsc_byte_if  chars_if ();
	tsc_token_if tokens_if ();

	token_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Scanner model: own copy of the scan state
	// ------------------------------------------------------------------------
	string punct_set = ":;,+-*/%()[]=";
	string keyword_list [tsc_pkg::NKW] = '{
		"begin", "end", "and", "or", "create", "print", "if", "endif",
		"ifbody", "else", "do", "not", "while", "whilebody", "endwhile"
	};

	scan_state_t                     scan_state;
	logic [tsc_pkg::POS_WIDTH-1:0]   next_pos;
	logic [tsc_pkg::POS_WIDTH-1:0]   tok_begin;
	// Identifier text; ten bytes are enough to tell any keyword apart
	logic [tsc_pkg::CHAR_W-1:0]      ident_buf [tsc_pkg::KW_MAX + 1];
	int                              ident_len;

	scan_token_t            run_tokens [$];  // tokens closed by the current byte
	scan_token_t            tokens_due [$];  // tokens the block still owes

	int send_idle_pct = 30;
	int take_idle_pct = 30;
	int bytes_fed = 0;
	int mismatch_count = 0;

	function automatic bit digit_char(input logic [tsc_pkg::CHAR_W-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_char(input logic [tsc_pkg::CHAR_W-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit blank_char(input logic [tsc_pkg::CHAR_W-1:0] c);
		return c == tsc_pkg::CH_SPACE || c == tsc_pkg::CH_TAB || c == tsc_pkg::CH_NEWLINE;
	endfunction

	function automatic bit ident_char(input logic [tsc_pkg::CHAR_W-1:0] c);
		return letter_char(c) || digit_char(c) || c == tsc_pkg::CH_UNDERSCORE;
	endfunction

	function automatic int punct_index(input logic [tsc_pkg::CHAR_W-1:0] c);
		for (int i = 0; i < tsc_pkg::NPUNCT; i++)
			if (punct_set[i] == c)
				return i;
		return -1;
	endfunction

	// True for any byte that is legal between tokens
	function automatic bit starts_token(input logic [tsc_pkg::CHAR_W-1:0] c);
		return c == tsc_pkg::CH_NUL || blank_char(c) || punct_index(c) >= 0
			|| digit_char(c) || c == tsc_pkg::CH_QUOTE || letter_char(c)
			|| c == tsc_pkg::CH_UNDERSCORE;
	endfunction

	function automatic void emit(input logic [tsc_pkg::KIND_W-1:0] kind,
			input longint start, input longint len);
		scan_token_t t;
		t.kind   = kind;
		t.start  = (start > longint'(tsc_pkg::TOK_MAX)) ? tsc_pkg::TOK_MAX
			: tsc_pkg::TOK_W'(start);
		t.length = (len > longint'(tsc_pkg::TOK_MAX)) ? tsc_pkg::TOK_MAX
			: tsc_pkg::TOK_W'(len);
		t.last   = 1'b0;
		run_tokens.push_back(t);
	endfunction

	// Exact text match against the keyword list, else a plain identifier
	function automatic logic [tsc_pkg::KIND_W-1:0] word_kind();
		bit same;
		for (int k = 0; k < tsc_pkg::NKW; k++) begin
			if (keyword_list[k].len() == ident_len) begin
				same = 1'b1;
				for (int j = 0; j < ident_len; j++)
					if (keyword_list[k][j] != ident_buf[j])
						same = 1'b0;
				if (same)
					return tsc_pkg::KIND_KW0 + tsc_pkg::KIND_W'(k);
			end
		end
		return tsc_pkg::KIND_IDENT;
	endfunction

	// A byte seen between tokens
	function automatic void scan_fresh(input logic [tsc_pkg::CHAR_W-1:0] c,
			input longint here);
		int p;
		p = punct_index(c);
		scan_state = SCAN_IDLE;
		if (c == tsc_pkg::CH_NUL) begin
			emit(tsc_pkg::KIND_TERM, here, 0);
		end else if (p >= 0) begin
			emit(tsc_pkg::KIND_W'(p), here, 1);
		end else if (digit_char(c)) begin
			scan_state = SCAN_INT;
			tok_begin  = tsc_pkg::POS_WIDTH'(here);
		end else if (c == tsc_pkg::CH_QUOTE) begin
			scan_state = SCAN_STR;
			tok_begin  = tsc_pkg::POS_WIDTH'(here);
		end else if (letter_char(c) || c == tsc_pkg::CH_UNDERSCORE) begin
			scan_state   = SCAN_IDENT;
			tok_begin    = tsc_pkg::POS_WIDTH'(here);
			ident_buf[0] = c;
			ident_len    = 1;
		end else if (!blank_char(c)) begin
			scan_state = SCAN_HALT;
			emit(tsc_pkg::KIND_ERROR, here, 1);
		end
	endfunction

	// Advance the model by one accepted byte; closed tokens land in run_tokens
	function automatic void tokenize(input logic [tsc_pkg::CHAR_W-1:0] c);
		longint here;
		longint from;
		here = longint'(next_pos);
		from = longint'(tok_begin);
		run_tokens.delete();
		case (scan_state)
			SCAN_HALT: ;
			SCAN_INT, SCAN_FRAC: begin
				if (!digit_char(c)) begin
					if (c == tsc_pkg::CH_DOT && scan_state == SCAN_INT) begin
						scan_state = SCAN_DOT;
					end else begin
						emit(tsc_pkg::KIND_NUMBER, from, here - from);
						scan_fresh(c, here);
					end
				end
			end
			SCAN_DOT: begin
				if (digit_char(c)) begin
					scan_state = SCAN_FRAC;
				end else begin
					// error points back at the dot
					scan_state = SCAN_HALT;
					emit(tsc_pkg::KIND_ERROR, (here > 0) ? here - 1 : 0, 1);
				end
			end
			SCAN_STR: begin
				if (c == tsc_pkg::CH_QUOTE) begin
					emit(tsc_pkg::KIND_STRING, from, here - from + 1);
					scan_state = SCAN_IDLE;
				end else if (c == tsc_pkg::CH_NUL) begin
					scan_state = SCAN_HALT;
					emit(tsc_pkg::KIND_ERROR, here, 1);
				end
			end
			SCAN_IDENT: begin
				if (ident_char(c)) begin
					if (ident_len < tsc_pkg::KW_MAX + 1) begin
						ident_buf[ident_len] = c;
						ident_len++;
					end
				end else begin
					emit(word_kind(), from, here - from);
					scan_fresh(c, here);
				end
			end
			default: scan_fresh(c, here);
		endcase
		// position freezes on halt and sticks at its top value
		if (scan_state != SCAN_HALT && next_pos != POS_LAST)
			next_pos++;
	endfunction

	function automatic void queue_run();
		scan_token_t t;
		for (int i = 0; i < run_tokens.size(); i++) begin
			t = run_tokens[i];
			t.last = (i == run_tokens.size() - 1);
			tokens_due.push_back(t);
		end
	endfunction

	// Would this byte send the scanner into its halt from the present state?
	function automatic bit char_halts(input logic [tsc_pkg::CHAR_W-1:0] c);
		case (scan_state)
			SCAN_HALT:  return 1'b1;
			SCAN_DOT:   return !digit_char(c);
			SCAN_STR:   return c == tsc_pkg::CH_NUL;
			SCAN_INT:   if (digit_char(c) || c == tsc_pkg::CH_DOT) return 1'b0;
			SCAN_FRAC:  if (digit_char(c)) return 1'b0;
			SCAN_IDENT: if (ident_char(c)) return 1'b0;
			default: ;
		endcase
		return !starts_token(c);
	endfunction

	// ------------------------------------------------------------------------
	// Byte pickers for the random part
	// ------------------------------------------------------------------------
	function automatic logic [tsc_pkg::CHAR_W-1:0] blank_byte();
		case ($urandom_range(0, 2))
			0: return tsc_pkg::CH_SPACE;
			1: return tsc_pkg::CH_TAB;
			default: return tsc_pkg::CH_NEWLINE;
		endcase
	endfunction

	function automatic logic [tsc_pkg::CHAR_W-1:0] digit_byte();
		return "0" + tsc_pkg::CHAR_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [tsc_pkg::CHAR_W-1:0] ident_byte(input bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26)
			return "a" + tsc_pkg::CHAR_W'(r);
		if (r < 52)
			return "A" + tsc_pkg::CHAR_W'(r - 26);
		if (r == 52)
			return tsc_pkg::CH_UNDERSCORE;
		return "0" + tsc_pkg::CHAR_W'(r - 53);
	endfunction

	// Anything but a quote or 0 may sit inside a string
	function automatic logic [tsc_pkg::CHAR_W-1:0] string_byte();
		logic [tsc_pkg::CHAR_W-1:0] b;
		do
			b = tsc_pkg::CHAR_W'($urandom_range(1, 255));
		while (b == tsc_pkg::CH_QUOTE);
		return b;
	endfunction

	function automatic logic [tsc_pkg::CHAR_W-1:0] noise_byte();
		logic [tsc_pkg::CHAR_W-1:0] b;
		do
			b = tsc_pkg::CHAR_W'($urandom_range(0, 255));
		while (char_halts(b));
		return b;
	endfunction

	// ------------------------------------------------------------------------
	// Byte channel driver
	// ------------------------------------------------------------------------
	// Drives one word, waits for its handshake and steps the model
	task automatic feed(input logic [tsc_pkg::CHAR_W-1:0] c);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		tokenize(c);
		bytes_fed++;
	endtask

	task automatic feed_predicted(input logic [tsc_pkg::CHAR_W-1:0] c);
		feed(c);
		queue_run();
	endtask

	// Keeps the random part clear of the halt: completes a dangling dot,
	// separates with a blank where needed, and drops a byte that still halts
	task automatic feed_safe(input logic [tsc_pkg::CHAR_W-1:0] c);
		if (scan_state == SCAN_DOT && !digit_char(c))
			feed_predicted(digit_byte());
		if (char_halts(c))
			feed_predicted(tsc_pkg::CH_SPACE);
		if (!char_halts(c))
			feed_predicted(c);
	endtask

	// Mostly well-formed tokens with random content, some raw noise
	task automatic random_token();
		int choice;
		int k;
		int n;
		choice = $urandom_range(0, 99);
		if (choice < 10) begin
			repeat ($urandom_range(1, 3)) feed_safe(blank_byte());
		end else if (choice < 25) begin
			feed_safe(punct_set[$urandom_range(0, tsc_pkg::NPUNCT - 1)]);
		end else if (choice < 42) begin
			repeat ($urandom_range(1, 5)) feed_safe(digit_byte());
			if (choice >= 35) begin
				feed_safe(tsc_pkg::CH_DOT);
				repeat ($urandom_range(1, 4)) feed_safe(digit_byte());
			end
		end else if (choice < 55) begin
			feed_safe(tsc_pkg::CH_QUOTE);
			repeat ($urandom_range(0, 8)) feed_safe(string_byte());
			feed_safe(tsc_pkg::CH_QUOTE);
		end else if (choice < 67) begin
			feed_safe(ident_byte(1'b1));
			repeat ($urandom_range(0, 11)) feed_safe(ident_byte(1'b0));
		end else if (choice < 85) begin
			// keywords, and near misses: one short or one long
			k = $urandom_range(0, tsc_pkg::NKW - 1);
			n = keyword_list[k].len();
			if (choice >= 80 && $urandom_range(0, 1))
				n--;
			for (int j = 0; j < n; j++)
				feed_safe(keyword_list[k][j]);
			if (choice >= 80 && n == keyword_list[k].len())
				feed_safe(ident_byte(1'b0));
		end else if (choice < 90) begin
			feed_safe(tsc_pkg::CH_NUL);
		end else begin
			repeat ($urandom_range(1, 4)) feed_safe(noise_byte());
		end
		if ($urandom_range(0, 9) < 6)
			feed_safe(blank_byte());
	endtask

	// ------------------------------------------------------------------------
	// Token channel: random stalls and in-order checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	initial begin
		int stall_left;
		scan_token_t want;
		stall_left = 0;
		tokens_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && tokens_if.valid && tokens_if.ready) begin
				if (tokens_due.size() == 0) begin
					report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
						tokens_if.token_kind, tokens_if.token_start, tokens_if.token_len));
				end else begin
					want = tokens_due.pop_front();
					if (tokens_if.token_kind !== want.kind
							|| tokens_if.token_start !== want.start
							|| tokens_if.token_len !== want.length
							|| tokens_if.last_of_run !== want.last)
						report_mismatch($sformatf(
							"token %0d/%0d/%0d/%0b, wanted %0d/%0d/%0d/%0b",
							tokens_if.token_kind, tokens_if.token_start,
							tokens_if.token_len, tokens_if.last_of_run,
							want.kind, want.start, want.length, want.last));
				end
			end
			// stall bursts of random length
			if (stall_left > 0) begin
				stall_left--;
				tokens_if.ready <= 1'b0;
			end else if (take_idle_pct != 0 && $urandom_range(0, 99) < take_idle_pct) begin
				stall_left = $urandom_range(1, 11) - 1;
				tokens_if.ready <= 1'b0;
			end else begin
				tokens_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int random_stop;
		logic [tsc_pkg::CHAR_W-1:0] b;
		run_end_t how;
		scan_token_t typed_tok;

		arst_n             = 1'b0;
		chars_if.valid     = 1'b0;
		chars_if.char_code = '0;

		scan_state = SCAN_IDLE;
		next_pos   = '0;
		tok_begin  = '0;
		ident_len  = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening table
		foreach (OPENING_ROWS[i]) begin
			feed(OPENING_ROWS[i].code);
			if (!OPENING_ROWS[i].typed) begin
				queue_run();
			end else if (OPENING_ROWS[i].has_tok) begin
				typed_tok.kind   = OPENING_ROWS[i].kind;
				typed_tok.start  = OPENING_ROWS[i].start;
				typed_tok.length = OPENING_ROWS[i].length;
				typed_tok.last   = 1'b1;
				tokens_due.push_back(typed_tok);
			end
		end

		// Random tokens; idle rates on both sides change now and then,
		// including stretches with none at all
		random_stop = bytes_fed + RANDOM_WORDS;
		while (bytes_fed < random_stop) begin
			if ($urandom_range(0, 29) == 0) begin
				send_idle_pct = $urandom_range(0, 3) * 15;
				take_idle_pct = $urandom_range(0, 3) * 15;
			end
			random_token();
		end

		// Last part runs flat out
		send_idle_pct = 0;
		take_idle_pct = 0;
		repeat (20) random_token();

		// A halt lasts until reset, so the run closes on exactly one of them
		if (scan_state == SCAN_STR)
			feed_safe(tsc_pkg::CH_QUOTE);
		feed_safe(tsc_pkg::CH_SPACE);
		how = run_end_t'($urandom_range(0, 2));
		case (how)
			END_BAD_BYTE: begin
				do
					b = tsc_pkg::CHAR_W'($urandom_range(0, 255));
				while (starts_token(b));
				feed_predicted(b);
			end
			END_LONE_DOT: begin
				feed_predicted(digit_byte());
				feed_predicted(tsc_pkg::CH_DOT);
				do
					b = tsc_pkg::CHAR_W'($urandom_range(0, 255));
				while (digit_char(b));
				feed_predicted(b);
			end
			default: begin
				feed_predicted(tsc_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 3)) feed_predicted(string_byte());
				feed_predicted(tsc_pkg::CH_NUL);
			end
		endcase
		// halted: these words must raise no token
		repeat (6) feed_predicted(tsc_pkg::CHAR_W'($urandom_range(0, 255)));
		chars_if.valid <= 1'b0;

		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog, several times the slowest legal run
	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
